/* rtl/core/vfcl_pkg.sv */
// ----------------------------------------------------------------------------
// vfcl_pkg
// Shared types and constants of the voxel face culler: command codes, face
// codes, block types, render layers and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package vfcl_pkg;

	typedef logic [1:0] command_t;
	typedef logic [2:0] face_t;
	typedef logic [3:0] block_t;

	localparam command_t CMD_LOAD  = 2'd0;
	localparam command_t CMD_LIGHT = 2'd1;
	localparam command_t CMD_MESH  = 2'd2;

	// config register indexes
	localparam logic REG_CHUNK_X = 1'b0;
	localparam logic REG_CHUNK_Z = 1'b1;

	localparam face_t FACE_FRONT  = 3'd0;
	localparam face_t FACE_BACK   = 3'd1;
	localparam face_t FACE_TOP    = 3'd2;
	localparam face_t FACE_BOTTOM = 3'd3;
	localparam face_t FACE_RIGHT  = 3'd4;
	localparam face_t FACE_LEFT   = 3'd5;

	localparam block_t BT_EMPTY  = 4'd0;
	localparam block_t BT_GRASS  = 4'd4;
	localparam block_t BT_LEAVES = 4'd7;
	localparam block_t BT_SNOW   = 4'd9;

	localparam block_t LAYER_BOTTOM     = 4'd1;
	localparam block_t LAYER_GRASS_SIDE = 4'd8;
	localparam block_t LAYER_SNOW_SIDE  = 4'd11;

	localparam logic [7:0] BRIGHT_LIT  = 8'd255;
	localparam logic [7:0] BRIGHT_DARK = 8'd60;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic load_we;
		logic light_init;
		logic light_issue;
		logic capture;
		logic mesh_issue;
		logic emit;
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic light_last;
		logic rd_last;
		logic mask_empty;
	} stat_t;

endpackage

/* rtl/core/vfcl_in_if.sv */
// ----------------------------------------------------------------------------
// vfcl_in_if
// Request channel of the voxel face culler: one command with a voxel position.
// ----------------------------------------------------------------------------
interface vfcl_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [3:0] pos_x;
	logic [3:0] pos_y;
	logic [3:0] pos_z;
	logic [3:0] block_type;

	modport source (output valid, command, pos_x, pos_y, pos_z, block_type, input ready);
	modport sink   (input valid, command, pos_x, pos_y, pos_z, block_type, output ready);
endinterface

/* rtl/core/vfcl_out_if.sv */
// ----------------------------------------------------------------------------
// vfcl_out_if
// Face record channel of the voxel face culler.
// ----------------------------------------------------------------------------
interface vfcl_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         face_dir;
	logic [3:0]         render_layer;
	logic [7:0]         brightness;
	logic signed [24:0] global_x;
	logic [3:0]         global_y;
	logic signed [24:0] global_z;
	logic               last_face;

	modport source (output valid, face_dir, render_layer, brightness, global_x, global_y,
		global_z, last_face, input ready);
	modport sink   (input valid, face_dir, render_layer, brightness, global_x, global_y,
		global_z, last_face, output ready);
endinterface

/* rtl/core/vfcl_ctrl.sv */
// ----------------------------------------------------------------------------
// vfcl_ctrl
// Controller: sequences the clearing pass, loads, the lighting scan and the
// read and emit phases of a mesh request.
// ----------------------------------------------------------------------------
module vfcl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	input  vfcl_pkg::command_t command,
	output logic              ready,
	input  vfcl_pkg::stat_t   stat,
	output vfcl_pkg::ctrl_t   ctrl
);

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_LIGHT  = 7'b0000100,
		S_LDRAIN = 7'b0001000,
		S_MREAD  = 7'b0010000,
		S_MWAIT  = 7'b0100000,
		S_MEMIT  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign ready  = (state_q == S_IDLE);
	assign accept = valid & ready;

	always_comb begin
		state_d          = state_q;
		ctrl             = '0;
		ctrl.clear       = (state_q == S_CLEAR);
		ctrl.light_issue = (state_q == S_LIGHT);
		ctrl.mesh_issue  = (state_q == S_MREAD);
		ctrl.emit        = (state_q == S_MEMIT);
		case (state_q)
			S_CLEAR: begin
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					case (command)
						vfcl_pkg::CMD_LOAD: ctrl.load_we = 1'b1;
						vfcl_pkg::CMD_LIGHT: begin
							ctrl.light_init = 1'b1;
							state_d         = S_LIGHT;
						end
						vfcl_pkg::CMD_MESH: begin
							ctrl.capture = 1'b1;
							state_d      = S_MREAD;
						end
						default: ;
					endcase
				end
			end
			S_LIGHT: begin
				if (stat.light_last) state_d = S_LDRAIN;
			end
			S_LDRAIN: state_d = S_IDLE;
			S_MREAD: begin
				if (stat.rd_last) state_d = S_MWAIT;
			end
			S_MWAIT: state_d = S_MEMIT;
			S_MEMIT: begin
				if (stat.mask_empty) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

endmodule

/* rtl/core/vfcl_dpath.sv */
// ----------------------------------------------------------------------------
// vfcl_dpath
// Datapath: block and sunlight memories, config registers, lighting scan
// counters, neighbour read sequence, face mask and the output register.
// ----------------------------------------------------------------------------
module vfcl_dpath #(
	parameter int EDGE = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [20:0]      cfg_data,
	input  logic [3:0]       pos_x,
	input  logic [3:0]       pos_y,
	input  logic [3:0]       pos_z,
	input  logic [3:0]       block_type,
	input  vfcl_pkg::ctrl_t  ctrl,
	output vfcl_pkg::stat_t  stat,
	vfcl_out_if.source       face
);

	localparam int VOX = EDGE * EDGE * EDGE;
	localparam int AW  = $clog2(VOX);
	localparam int CW  = $clog2(EDGE);
	localparam logic [CW-1:0] CMAX = CW'(EDGE - 1);
	localparam logic [6:0]    EDGE_W = 7'(EDGE);

	logic [3:0] bmem [VOX];
	logic       smem [VOX];

	logic [20:0] chunk_x_q, chunk_z_q;

	function automatic logic [AW-1:0] vaddr(input logic [CW-1:0] x, input logic [CW-1:0] y,
		input logic [CW-1:0] z);
		return AW'(x) * AW'(EDGE * EDGE) + AW'(y) * AW'(EDGE) + AW'(z);
	endfunction

	function automatic logic [2:0] first_bit(input logic [5:0] m);
		logic [2:0] r;
		r = 3'd0;
		for (int i = 5; i >= 0; i--) begin
			if (m[i]) r = 3'(i);
		end
		return r;
	endfunction

	function automatic vfcl_pkg::block_t layer_for(input vfcl_pkg::block_t t,
		input vfcl_pkg::face_t d);
		vfcl_pkg::block_t r;
		r = t;
		if (t == vfcl_pkg::BT_GRASS || t == vfcl_pkg::BT_SNOW) begin
			if (d == vfcl_pkg::FACE_TOP) r = t;
			else if (d == vfcl_pkg::FACE_BOTTOM) r = vfcl_pkg::LAYER_BOTTOM;
			else if (t == vfcl_pkg::BT_GRASS) r = vfcl_pkg::LAYER_GRASS_SIDE;
			else r = vfcl_pkg::LAYER_SNOW_SIDE;
		end
		return r;
	endfunction

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_x_q <= '0;
			chunk_z_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == vfcl_pkg::REG_CHUNK_X) chunk_x_q <= cfg_data;
			else chunk_z_q <= cfg_data;
		end
	end

	// clearing pass counter
	logic [AW-1:0] clr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (ctrl.clear) clr_q <= clr_q + AW'(1);
	end
	assign stat.clr_last = (clr_q == AW'(VOX - 1));

	// raw load address
	logic          load_in;
	logic [AW-1:0] load_addr;
	assign load_in = (7'(pos_x) < EDGE_W) && (7'(pos_y) < EDGE_W) && (7'(pos_z) < EDGE_W);
	assign load_addr = vaddr(CW'(pos_x), CW'(pos_y), CW'(pos_z));

	// lighting scan: x, then z, then y from the top down
	logic [CW-1:0] lx_q, ly_q, lz_q;
	logic [AW-1:0] laddr;
	assign laddr = vaddr(lx_q, ly_q, lz_q);
	assign stat.light_last = (lx_q == CMAX) && (lz_q == CMAX) && (ly_q == '0);

	always_ff @(posedge clk) begin
		if (ctrl.light_init) begin
			lx_q <= '0;
			lz_q <= '0;
			ly_q <= CMAX;
		end else if (ctrl.light_issue) begin
			if (ly_q == '0) begin
				ly_q <= CMAX;
				if (lz_q == CMAX) begin
					lz_q <= '0;
					lx_q <= lx_q + CW'(1);
				end else begin
					lz_q <= lz_q + CW'(1);
				end
			end else begin
				ly_q <= ly_q - CW'(1);
			end
		end
	end

	logic          lv_s1, lfirst_s1, shadow_q, shadow_eff;
	logic [AW-1:0] laddr_s1;
	logic [3:0]    bdata_q;
	logic          sdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lv_s1 <= 1'b0;
		else lv_s1 <= ctrl.light_issue;
	end

	always_ff @(posedge clk) begin
		laddr_s1  <= laddr;
		lfirst_s1 <= (ly_q == CMAX);
		if (lv_s1) shadow_q <= shadow_eff ||
			(bdata_q != vfcl_pkg::BT_EMPTY && bdata_q != vfcl_pkg::BT_LEAVES);
	end
	assign shadow_eff = !lfirst_s1 && shadow_q;

	// mesh request capture and neighbour reads
	logic [3:0]    px_q, py_q, pz_q;
	logic          inr_q;
	logic [2:0]    rd_q;
	logic [CW-1:0] cx, cy, cz;
	logic [AW-1:0] maddr;
	logic          min;

	assign cx = CW'(px_q);
	assign cy = CW'(py_q);
	assign cz = CW'(pz_q);
	assign stat.rd_last = (rd_q == 3'd6);

	always_comb begin
		maddr = vaddr(cx, cy, cz);
		min   = 1'b1;
		case (rd_q)
			3'd1: begin
				maddr = vaddr(cx, cy, cz + CW'(1));
				min   = (cz != CMAX);
			end
			3'd2: begin
				maddr = vaddr(cx, cy, cz - CW'(1));
				min   = (cz != '0);
			end
			3'd3: begin
				maddr = vaddr(cx, cy + CW'(1), cz);
				min   = (cy != CMAX);
			end
			3'd4: begin
				maddr = vaddr(cx, cy - CW'(1), cz);
				min   = (cy != '0);
			end
			3'd5: begin
				maddr = vaddr(cx + CW'(1), cy, cz);
				min   = (cx != CMAX);
			end
			3'd6: begin
				maddr = vaddr(cx - CW'(1), cy, cz);
				min   = (cx != '0);
			end
			default: ;
		endcase
	end

	logic                 rv_s1, rin_s1;
	logic [2:0]           rk_s1;
	vfcl_pkg::block_t     type_q;
	logic [5:0]           vis_q, lit_q, emask;
	logic [24:0]          gx_q, gz_q;
	vfcl_pkg::face_t      dsel, rdir;
	logic                 out_free, do_emit;

	assign rdir = rk_s1 - 3'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			rv_s1 <= 1'b0;
		end else begin
			rv_s1 <= ctrl.mesh_issue;
			if (ctrl.capture) rd_q <= '0;
			else if (ctrl.mesh_issue) rd_q <= rd_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		rk_s1  <= rd_q;
		rin_s1 <= min;
		gx_q   <= {{4{chunk_x_q[20]}}, chunk_x_q} * 25'(EDGE) + 25'(px_q);
		gz_q   <= {{4{chunk_z_q[20]}}, chunk_z_q} * 25'(EDGE) + 25'(pz_q);
		if (ctrl.capture) begin
			px_q  <= pos_x;
			py_q  <= pos_y;
			pz_q  <= pos_z;
			inr_q <= load_in;
			vis_q <= '0;
		end else if (rv_s1) begin
			if (rk_s1 == 3'd0) begin
				type_q <= bdata_q;
			end else begin
				// bottom face at the floor of the chunk never shows
				vis_q[rdir] <= (!rin_s1 || bdata_q == vfcl_pkg::BT_EMPTY) &&
					!(rdir == vfcl_pkg::FACE_BOTTOM && py_q == 4'd0);
				lit_q[rdir] <= !rin_s1 || sdata_q;
			end
		end else if (do_emit) begin
			vis_q[dsel] <= 1'b0;
		end
	end

	assign emask = vis_q & {6{inr_q && type_q != vfcl_pkg::BT_EMPTY}};
	assign stat.mask_empty = (emask == '0);
	assign dsel = first_bit(emask);
	assign out_free = !face.valid || face.ready;
	assign do_emit = ctrl.emit && out_free && (emask != '0);

	// memories
	logic [AW-1:0] raddr;
	assign raddr = ctrl.light_issue ? laddr : maddr;

	always_ff @(posedge clk) begin
		bdata_q <= bmem[raddr];
		sdata_q <= smem[raddr];
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) bmem[clr_q] <= '0;
		else if (ctrl.load_we && load_in) bmem[load_addr] <= block_type;
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) smem[clr_q] <= 1'b0;
		else if (lv_s1) smem[laddr_s1] <= !shadow_eff;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) face.valid <= 1'b0;
		else if (do_emit) face.valid <= 1'b1;
		else if (face.ready) face.valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (do_emit) begin
			face.face_dir     <= dsel;
			face.render_layer <= layer_for(type_q, dsel);
			face.brightness   <= lit_q[dsel] ? vfcl_pkg::BRIGHT_LIT : vfcl_pkg::BRIGHT_DARK;
			face.global_x     <= gx_q;
			face.global_y     <= py_q;
			face.global_z     <= gz_q;
			face.last_face    <= ((emask & ~(6'd1 << dsel)) == '0);
		end
	end

endmodule

/* rtl/core/voxel_face_cull_light.sv */
// ----------------------------------------------------------------------------
// voxel_face_cull_light
// Voxel chunk face culler with column sunlight.
//
// voxel carries requests: load one block type, relight the chunk, or mesh one
// voxel. face carries one record per visible face of a meshed voxel, in the
// order front, back, top, bottom, right, left, the final one with last_face.
// chunk_x and chunk_z are written through cfg_we, cfg_index and cfg_data.
// After reset a clearing pass empties both stores; no request is taken
// meanwhile. A load is written straight into the block store. Lighting
// scans one voxel per cycle through the single block memory read port.
// A mesh request, once accepted, reads the voxel and its six neighbours,
// one per cycle, waits for the last read to land, then emits one record
// per visible face and returns to idle when the face mask is empty.
// The final record sits in an output register, so the next request is taken
// while it waits; a stalled receiver holds each further record and the
// block waits with it.
// ----------------------------------------------------------------------------
module voxel_face_cull_light #(
	parameter int EDGE = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [20:0] cfg_data,
	vfcl_in_if.sink     voxel,
	vfcl_out_if.source  face
);

	vfcl_pkg::ctrl_t ctrl;
	vfcl_pkg::stat_t stat;

	vfcl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (voxel.valid),
		.command (voxel.command),
		.ready   (voxel.ready),
		.stat    (stat),
		.ctrl    (ctrl)
	);

	vfcl_dpath #(
		.EDGE (EDGE)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pos_x      (voxel.pos_x),
		.pos_y      (voxel.pos_y),
		.pos_z      (voxel.pos_z),
		.block_type (voxel.block_type),
		.ctrl       (ctrl),
		.stat       (stat),
		.face       (face)
	);

endmodule
